>>> rtl/twt_pkg.sv
// twt_pkg: shared constants, controller states and control structs
// for the trapped water block; no dependencies
`default_nettype none

package twt_pkg;

    localparam int TWT_HEIGHT_W        = 16;    // width of the height field
    localparam int TWT_TOTAL_W         = 26;    // width of the water total
    localparam int TWT_MAX_BARS_DEF    = 1024;
    localparam int TWT_HEIGHT_BITS_DEF = 16;

    localparam logic [TWT_TOTAL_W-1:0] TWT_TOTAL_MAX = {TWT_TOTAL_W{1'b1}};

    typedef enum logic [1:0] {
        S_LOAD,     // taking bars
        S_START,    // arm the backward walk
        S_WALK,     // backward walk over the store
        S_DONE      // hand the total to the output register
    } t_twt_state;

    // controller to datapath
    typedef struct packed {
        logic load;         // store one bar
        logic walk_start;   // set read pointer to the bar count
        logic walk_step;    // issue one read while entries remain
        logic emit;         // load result register and clear the set
    } t_twt_cmd;

    // datapath to controller
    typedef struct packed {
        logic walk_done;    // no read left and nothing in flight
        logic out_full;     // result register cannot take a new result
    } t_twt_stat;

endpackage

`default_nettype wire

>>> rtl/twt_if.sv
// twt_if: valid/ready channel interfaces for bar requests and results
// depends on twt_pkg for field widths
`default_nettype none

interface twt_bar_if
    import twt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [TWT_HEIGHT_W-1:0] height;
    logic                    last_bar;

    modport source (output valid, output height, output last_bar, input ready);
    modport sink   (input valid, input height, input last_bar, output ready);
endinterface

interface twt_res_if
    import twt_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [TWT_TOTAL_W-1:0] water_total;
    logic                   overflow;

    modport source (output valid, output water_total, output overflow, input ready);
    modport sink   (input valid, input water_total, input overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/twt_ctrl.sv
// twt_ctrl: sequencer for load, backward walk and result hand-off
// depends on twt_pkg
`default_nettype none

module twt_ctrl
    import twt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_bar_valid,
    input  wire logic      i_bar_last,
    input  wire t_twt_stat i_stat,
    output logic           o_bar_ready,
    output t_twt_cmd       o_cmd
);

    t_twt_state r_state;
    t_twt_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_bar_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_LOAD: begin
                o_bar_ready = 1'b1;
                if (i_bar_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_bar_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                o_cmd.walk_start = 1'b1;
                n_state          = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/twt_dp.sv
// twt_dp: bar store, running maxima, water accumulator and result register
// depends on twt_pkg; commanded by twt_ctrl
`default_nettype none

module twt_dp
    import twt_pkg::*;
#(
    parameter int MAX_BARS    = TWT_MAX_BARS_DEF,
    parameter int HEIGHT_BITS = TWT_HEIGHT_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_twt_cmd                i_cmd,
    input  wire logic [TWT_HEIGHT_W-1:0] i_height,
    input  wire logic                    i_res_ready,
    output t_twt_stat                    o_stat,
    output logic                         o_res_valid,
    output logic [TWT_TOTAL_W-1:0]       o_water_total,
    output logic                         o_overflow
);

    localparam int AW    = $clog2(MAX_BARS);
    localparam int CW    = $clog2(MAX_BARS + 1);
    localparam int HB    = HEIGHT_BITS;
    localparam int SUM_W = ((HB > TWT_TOTAL_W) ? HB : TWT_TOTAL_W) + 1;

    localparam logic [CW-1:0]    CNT_FULL = CW'(MAX_BARS);
    localparam logic [CW-1:0]    CNT_ONE  = CW'(1);
    localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(TWT_TOTAL_MAX);

    // store entry: {left max, height}
    logic [2*HB-1:0] mem [MAX_BARS];

    logic [CW-1:0]          r_count;
    logic [HB-1:0]          r_lmax;
    logic                   r_ovf;
    logic [CW-1:0]          r_ptr;
    logic                   r_vld_q;
    logic                   r_inner_q;
    logic [2*HB-1:0]        r_rd_q;
    logic [HB-1:0]          r_rmax;
    logic [TWT_TOTAL_W-1:0] r_acc;
    logic                   r_res_valid;
    logic [TWT_TOTAL_W-1:0] r_res_total;
    logic                   r_res_ovf;

    logic [31:0]         w_h_ext;
    logic [HB-1:0]       w_h;
    logic [HB-1:0]       n_lmax;
    logic                w_full;
    logic                w_issue;
    logic [CW-1:0]       w_ptr_m1;
    logic [HB-1:0]       w_q_h;
    logic [HB-1:0]       w_q_lm;
    logic [HB-1:0]       n_rmax;
    logic [HB-1:0]       w_lvl;
    logic [SUM_W-1:0]    w_sum;
    logic [TWT_TOTAL_W-1:0] n_acc;

    assign w_h_ext = {{(32 - TWT_HEIGHT_W){1'b0}}, i_height};
    assign w_h     = w_h_ext[HB-1:0];
    assign n_lmax  = (w_h > r_lmax) ? w_h : r_lmax;
    assign w_full  = (r_count == CNT_FULL);

    assign w_issue  = i_cmd.walk_step && (r_ptr != '0);
    assign w_ptr_m1 = r_ptr - CNT_ONE;

    assign w_q_h  = r_rd_q[HB-1:0];
    assign w_q_lm = r_rd_q[2*HB-1:HB];
    assign n_rmax = (w_q_h > r_rmax) ? w_q_h : r_rmax;
    assign w_lvl  = (n_rmax < w_q_lm) ? n_rmax : w_q_lm;
    assign w_sum  = SUM_W'(r_acc) + SUM_W'(w_lvl - w_q_h);

    always_comb begin
        n_acc = r_acc;
        if (r_inner_q && (w_lvl > w_q_h)) begin
            n_acc = (w_sum > SUM_MAX) ? TWT_TOTAL_MAX : w_sum[TWT_TOTAL_W-1:0];
        end
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            mem[r_count[AW-1:0]] <= {n_lmax, w_h};
        end
        if (w_issue) begin
            r_rd_q <= mem[w_ptr_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_inner_q <= (r_ptr != r_count) && (r_ptr != CNT_ONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lmax  <= '0;
            r_ovf   <= 1'b0;
            r_ptr   <= '0;
            r_vld_q <= 1'b0;
            r_rmax  <= '0;
            r_acc   <= '0;
        end else begin
            r_vld_q <= w_issue;
            if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_ONE;
                    r_lmax  <= n_lmax;
                end
            end
            if (i_cmd.walk_start) begin
                r_ptr  <= r_count;
                r_rmax <= '0;
                r_acc  <= '0;
            end else begin
                if (w_issue) begin
                    r_ptr <= w_ptr_m1;
                end
                if (r_vld_q) begin
                    r_rmax <= n_rmax;
                    r_acc  <= n_acc;
                end
            end
            if (i_cmd.emit) begin
                r_count <= '0;
                r_lmax  <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res_total <= r_acc;
            r_res_ovf   <= r_ovf;
        end
    end

    assign o_stat.walk_done = (r_ptr == '0) && !r_vld_q;
    assign o_stat.out_full  = r_res_valid && !i_res_ready;
    assign o_res_valid      = r_res_valid;
    assign o_water_total    = r_res_total;
    assign o_overflow       = r_res_ovf;

endmodule

`default_nettype wire

>>> rtl/trapped_water_total.sv
// trapped_water_total: top level of the trapped rain water engine
// depends on twt_pkg, twt_if, twt_ctrl and twt_dp
//
//  channel  dir  handshake        payload
//  i_bar    in   valid / ready    height[15:0], last_bar
//  o_res    out  valid / ready    water_total[25:0], overflow
//
// a bar request that is not last is accepted while loading; the set then accepts the
// next bar in the following cycle
// after a last bar request no bar is taken until the set is walked: arming, then
// one read of the bar store per stored bar in the backward walk, the registered
// read data, and hand-off
// synchronous active-low reset clears the control state and the per-set
// counters; the bar store is not cleared, every entry is written before read
// a stalled result holds in the output register; the next set still loads
// and walks, then waits at hand-off until that register is free, taking no
// bar during that wait
`default_nettype none

module trapped_water_total
    import twt_pkg::*;
#(
    parameter int MAX_BARS    = TWT_MAX_BARS_DEF,
    parameter int HEIGHT_BITS = TWT_HEIGHT_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    twt_bar_if.sink   i_bar,
    twt_res_if.source o_res
);

    t_twt_cmd  w_cmd;
    t_twt_stat w_stat;
    logic      w_bar_ready;

    // sequencer: load, arm, walk, hand off
    twt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bar_valid (i_bar.valid),
        .i_bar_last  (i_bar.last_bar),
        .i_stat      (w_stat),
        .o_bar_ready (w_bar_ready),
        .o_cmd       (w_cmd)
    );

    // store, maxima, accumulator and result register
    twt_dp #(
        .MAX_BARS    (MAX_BARS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_height      (i_bar.height),
        .i_res_ready   (o_res.ready),
        .o_stat        (w_stat),
        .o_res_valid   (o_res.valid),
        .o_water_total (o_res.water_total),
        .o_overflow    (o_res.overflow)
    );

    assign i_bar.ready = w_bar_ready;

endmodule

`default_nettype wire
